@@ hdl/sfpw_pkg.sv @@
// Shared constants, types and command record for the SPI flash page-split writer.
package sfpw_pkg;

    localparam int PAGE_BYTES   = 256;              // power of two
    localparam int PAGE_LSB     = $clog2(PAGE_BYTES);
    localparam int ADDRESS_BITS = 24;
    localparam int HDR_W        = 24;               // address bits carried in the header
    localparam int CNT_W        = 24;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [7:0]       OPCODE_RESET = 8'd88;
    localparam logic [7:0]       MARKER_RESET = 8'd36;

    localparam logic REG_OPCODE = 1'b0;
    localparam logic REG_MARKER = 1'b1;

    typedef struct packed {
        logic [7:0]       data;
        logic             hdr;
        logic [HDR_W-1:0] addr;
        logic [CNT_W-1:0] cnt_before;
        logic [CNT_W-1:0] cnt_after;
        logic             close;
        logic             marker;
        logic [HDR_W-1:0] maddr;
    } t_cmd;

endpackage

@@ hdl/sfpw_front.sv @@
// Front end: tracks address, open frame and byte count, turns each input word into a command.
module sfpw_front import sfpw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_first_byte,
    input  logic [23:0]             i_start_address,
    input  logic                    i_last_byte,
    input  logic                    i_append_marker,
    output t_cmd                    o_cmd
);

    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic                    r_open, n_open;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic [ADDRESS_BITS-1:0] w_addr;
    logic [CNT_W-1:0]        w_cnt;
    logic                    w_open;
    logic                    w_close;

    always_comb begin
        w_addr  = i_first_byte ? ADDRESS_BITS'(i_start_address) : r_addr;
        w_cnt   = i_first_byte ? '0 : r_cnt;
        w_open  = i_first_byte ? 1'b0 : r_open;
        w_close = i_last_byte || (&w_addr[PAGE_LSB-1:0]) || (&w_addr);

        n_addr = w_addr + 1'b1;
        n_cnt  = (w_cnt == COUNT_MAX) ? COUNT_MAX : w_cnt + 1'b1;
        n_open = !w_close;

        o_cmd.data       = i_data_byte;
        o_cmd.hdr        = !w_open;
        o_cmd.addr       = HDR_W'(w_addr);
        o_cmd.cnt_before = w_cnt;
        o_cmd.cnt_after  = n_cnt;
        o_cmd.close      = w_close;
        o_cmd.marker     = i_last_byte && i_append_marker;
        o_cmd.maddr      = HDR_W'(n_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_open <= 1'b0;
            r_cnt  <= '0;
        end else if (i_push) begin
            r_addr <= n_addr;
            r_open <= n_open;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ hdl/sfpw_fifo.sv @@
// Short command queue between front and back ends.
module sfpw_fifo import sfpw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/sfpw_back.sv @@
// Back end: head command to SPI bytes in the output register, one per cycle unless stalled.
module sfpw_back import sfpw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_head,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic [7:0]       i_write_opcode,
    input  logic [7:0]       i_marker_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_spi_byte,
    output logic             o_frame_end,
    output logic             o_last,
    output logic [CNT_W-1:0] o_bytes_done
);

    typedef enum logic [3:0] {
        STEP_H0, STEP_H1, STEP_H2, STEP_H3, STEP_DATA,
        STEP_M0, STEP_M1, STEP_M2, STEP_M3, STEP_MK
    } t_step;

    t_step            r_step, w_cur, w_next;
    logic             r_mid;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_fe;
    logic             r_last;
    logic [CNT_W-1:0] r_cnt;

    logic             w_emit, w_done, w_fe;
    logic [7:0]       w_byte;
    logic [CNT_W-1:0] w_cnt;

    always_comb begin
        w_cur  = r_mid ? r_step : (i_head.hdr ? STEP_H0 : STEP_DATA);
        w_emit = !i_empty && (!r_valid || i_ready);
        w_done = (w_cur == STEP_MK) || (w_cur == STEP_DATA && !i_head.marker);
        o_pop  = w_emit && w_done;
        w_fe   = 1'b0;
        w_cnt  = i_head.cnt_after;
        unique case (w_cur)
            STEP_H0: begin
                w_byte = i_write_opcode;
                w_cnt  = i_head.cnt_before;
                w_next = STEP_H1;
            end
            STEP_H1: begin
                w_byte = i_head.addr[23:16];
                w_cnt  = i_head.cnt_before;
                w_next = STEP_H2;
            end
            STEP_H2: begin
                w_byte = i_head.addr[15:8];
                w_cnt  = i_head.cnt_before;
                w_next = STEP_H3;
            end
            STEP_H3: begin
                w_byte = i_head.addr[7:0];
                w_cnt  = i_head.cnt_before;
                w_next = STEP_DATA;
            end
            STEP_DATA: begin
                w_byte = i_head.data;
                w_fe   = i_head.close;
                w_next = STEP_M0;
            end
            STEP_M0: begin
                w_byte = i_write_opcode;
                w_next = STEP_M1;
            end
            STEP_M1: begin
                w_byte = i_head.maddr[23:16];
                w_next = STEP_M2;
            end
            STEP_M2: begin
                w_byte = i_head.maddr[15:8];
                w_next = STEP_M3;
            end
            STEP_M3: begin
                w_byte = i_head.maddr[7:0];
                w_next = STEP_MK;
            end
            STEP_MK: begin
                w_byte = i_marker_byte;
                w_fe   = 1'b1;
                w_next = STEP_H0;
            end
            default: begin
                w_byte = i_head.data;
                w_next = STEP_H0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_H0;
            r_mid   <= 1'b0;
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_step  <= w_next;
            r_mid   <= !w_done;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= w_byte;
            r_fe   <= w_fe;
            r_last <= w_done;
            r_cnt  <= w_cnt;
        end
    end

    assign o_valid      = r_valid;
    assign o_spi_byte   = r_byte;
    assign o_frame_end  = r_fe;
    assign o_last       = r_last;
    assign o_bytes_done = r_cnt;

endmodule

@@ hdl/spi_flash_page_split_writer.sv @@
// Top level of the SPI flash page-split writer: config registers, front, queue, back.
//
//  channel  | dir | handshake                 | payload
//  s_axis   | in  | s_axis_tvalid/tready      | tdata: data_byte, start_address; tuser; tlast
//  m_axis   | out | m_axis_tvalid/tready      | tdata: spi_byte, bytes_done; tuser; tlast
//  apb      | in  | psel, penable, pready     | paddr, pwdata, prdata
//
//  One output word per cycle unless the output stalls; an input word yields 1 to 10
//  output words (header 4, data 1, marker frame 5), so its cost is set by the back
//  end's byte sequencer. Input words are taken every cycle while the 4-entry command
//  queue has room. Reset is synchronous, active low; it clears the queue, the output
//  valid, address, count and frame state; registers return to opcode 88, marker 36.
//  A stalled output holds its word; the front keeps accepting until the queue fills.
module spi_flash_page_split_writer import sfpw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] data_byte, [31:8] start_address
    input  logic [1:0]  s_axis_tuser,   // [0] first_byte, [1] append_marker
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] spi_byte, [31:8] bytes_done
    output logic        m_axis_tuser,   // [0] frame_end
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_write_opcode, r_marker_byte;
    logic       w_wr;
    logic       w_push, w_pop, w_full, w_empty;
    t_cmd       w_cmd, w_head;
    logic [7:0] w_spi_byte;
    logic [CNT_W-1:0] w_bytes_done;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_opcode <= OPCODE_RESET;
            r_marker_byte  <= MARKER_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_OPCODE) begin
                r_write_opcode <= pwdata[7:0];
            end else begin
                r_marker_byte <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, (paddr[2] == REG_MARKER) ? r_marker_byte : r_write_opcode};

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    sfpw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .i_data_byte     (s_axis_tdata[7:0]),
        .i_first_byte    (s_axis_tuser[0]),
        .i_start_address (s_axis_tdata[31:8]),
        .i_last_byte     (s_axis_tlast),
        .i_append_marker (s_axis_tuser[1]),
        .o_cmd           (w_cmd)
    );

    sfpw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    sfpw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_write_opcode (r_write_opcode),
        .i_marker_byte  (r_marker_byte),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_spi_byte     (w_spi_byte),
        .o_frame_end    (m_axis_tuser),
        .o_last         (m_axis_tlast),
        .o_bytes_done   (w_bytes_done)
    );

    assign m_axis_tdata = {w_bytes_done, w_spi_byte};

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled right after reset");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("queue filled without an accepted word");

endmodule
